// ===== design/pcmc_pkg.sv =====
// shared types and constants for the pla cube cover lookup
// no dependencies; used by the controller, datapath and top modules by scoped name
`timescale 1ns / 1ps

package pcmc_pkg;

  localparam int VAR_W    = 10;  // care, value and minterm width
  localparam int OUT_W    = 13;  // output bits per cube
  localparam int IDX_W    = 9;   // reported cube index width
  localparam int SLOTS    = 4;   // reported covers
  localparam int CNT_W    = 3;   // cover count width
  localparam int CFG_W    = 4;   // config register width
  localparam int MAX_VARS = 10;
  localparam int MAX_OUTS = 13;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic q_start;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic scan_last;
  } status_t;

endpackage

// ===== design/pcmc_ram.sv =====
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pcmc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/pcmc_ctrl.sv =====
// controller state machine: accepts items, sequences the cube scan, loads the result
// depends on pcmc_pkg
`timescale 1ns / 1ps

module pcmc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  output logic             out_valid,
  input  logic             out_stall,
  input  pcmc_pkg::status_t status,
  output pcmc_pkg::cmd_t   cmd
);

  pcmc_pkg::state_t state;
  pcmc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != pcmc_pkg::ST_IDLE);
    case (state)
      pcmc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (action)
            pcmc_pkg::ACT_CLEAR: cmd.clear = 1'b1;
            pcmc_pkg::ACT_LOAD:  cmd.load  = !status.full;
            pcmc_pkg::ACT_QUERY: begin
              cmd.q_start = 1'b1;
              state_next  = status.count_zero ? pcmc_pkg::ST_FIN : pcmc_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      pcmc_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.scan_last) begin
          state_next = pcmc_pkg::ST_TAIL;
        end
      end
      // last read data is checked in this cycle
      pcmc_pkg::ST_TAIL: state_next = pcmc_pkg::ST_FIN;
      pcmc_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = pcmc_pkg::ST_IDLE;
        end
      end
      default: state_next = pcmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/pcmc_dp.sv =====
// datapath: cube store, cube count, scan pointer, cover accumulation, result register
// depends on pcmc_pkg and pcmc_ram
`timescale 1ns / 1ps

module pcmc_dp #(
  parameter int MAX_CUBES = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pcmc_pkg::cmd_t                         cmd,
  output pcmc_pkg::status_t                      status,
  input  logic [pcmc_pkg::CFG_W-1:0]             var_count,
  input  logic [pcmc_pkg::CFG_W-1:0]             out_count,
  input  logic [pcmc_pkg::VAR_W-1:0]             cube_care,
  input  logic [pcmc_pkg::VAR_W-1:0]             cube_value,
  input  logic [pcmc_pkg::OUT_W-1:0]             cube_outs,
  input  logic [pcmc_pkg::VAR_W-1:0]             minterm,
  output logic [pcmc_pkg::VAR_W-1:0]             query_minterm,
  output logic [pcmc_pkg::OUT_W-1:0]             out_bits,
  output logic [pcmc_pkg::CNT_W-1:0]             cover_count,
  output logic signed [pcmc_pkg::IDX_W-1:0]      cover_a,
  output logic signed [pcmc_pkg::IDX_W-1:0]      cover_b,
  output logic signed [pcmc_pkg::IDX_W-1:0]      cover_c,
  output logic signed [pcmc_pkg::IDX_W-1:0]      cover_d,
  output logic                                   too_many
);

  localparam int AW = (MAX_CUBES > 1) ? $clog2(MAX_CUBES) : 1;
  localparam int CW = $clog2(MAX_CUBES + 1);
  localparam int EW = 2 * pcmc_pkg::VAR_W + pcmc_pkg::OUT_W;

  logic [CW-1:0]                   cube_count;
  logic [AW-1:0]                   scan_idx;
  logic                            rd_vld;
  logic [AW-1:0]                   rd_idx;
  logic [pcmc_pkg::VAR_W-1:0]      mt;
  logic [pcmc_pkg::CNT_W-1:0]      n;
  logic [pcmc_pkg::OUT_W-1:0]      last_outs;
  logic                            over;
  logic [pcmc_pkg::IDX_W-1:0]      covers [pcmc_pkg::SLOTS];

  logic [AW-1:0]                   ram_addr;
  logic [EW-1:0]                   ram_wdata;
  logic [EW-1:0]                   ram_rdata;
  logic [pcmc_pkg::VAR_W-1:0]      rd_care;
  logic [pcmc_pkg::VAR_W-1:0]      rd_value;
  logic [pcmc_pkg::OUT_W-1:0]      rd_outs;
  logic [pcmc_pkg::CFG_W-1:0]      vc;
  logic [pcmc_pkg::CFG_W-1:0]      oc;
  logic [pcmc_pkg::VAR_W:0]        vmask_w;
  logic [pcmc_pkg::OUT_W:0]        omask_w;
  logic                            match;

  // loads never overlap a scan, so one port serves both
  assign ram_addr  = cmd.load ? cube_count[AW-1:0] : scan_idx;
  assign ram_wdata = {cube_care, cube_value, cube_outs};

  pcmc_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_CUBES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load),
    .re   (cmd.rd_en),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign {rd_care, rd_value, rd_outs} = ram_rdata;

  assign status.count_zero = (cube_count == '0);
  assign status.full       = (cube_count == CW'(MAX_CUBES));
  assign status.scan_last  = ((CW'(scan_idx) + CW'(1)) == cube_count);

  // clamp the counts to their limits and build low masks
  always_comb begin
    vc = (var_count > pcmc_pkg::CFG_W'(pcmc_pkg::MAX_VARS)) ?
         pcmc_pkg::CFG_W'(pcmc_pkg::MAX_VARS) : var_count;
    oc = (out_count > pcmc_pkg::CFG_W'(pcmc_pkg::MAX_OUTS)) ?
         pcmc_pkg::CFG_W'(pcmc_pkg::MAX_OUTS) : out_count;
    vmask_w = ((pcmc_pkg::VAR_W + 1)'(1) << vc) - (pcmc_pkg::VAR_W + 1)'(1);
    omask_w = ((pcmc_pkg::OUT_W + 1)'(1) << oc) - (pcmc_pkg::OUT_W + 1)'(1);
    match   = (((mt ^ rd_value) & rd_care & vmask_w[pcmc_pkg::VAR_W-1:0]) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cube_count <= '0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.clear) begin
        cube_count <= '0;
      end else if (cmd.load) begin
        cube_count <= cube_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      scan_idx <= '0;
    end else if (cmd.rd_en) begin
      scan_idx <= scan_idx + AW'(1);
    end
    if (cmd.rd_en) begin
      rd_idx <= scan_idx;
    end
  end

  // cover accumulation over the scan
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      mt        <= minterm;
      n         <= '0;
      over      <= 1'b0;
      last_outs <= '0;
      for (int s = 0; s < pcmc_pkg::SLOTS; s++) begin
        covers[s] <= '1;
      end
    end else if (rd_vld && match) begin
      if (n < pcmc_pkg::CNT_W'(pcmc_pkg::SLOTS)) begin
        covers[n[1:0]] <= pcmc_pkg::IDX_W'(rd_idx);
        n              <= n + pcmc_pkg::CNT_W'(1);
      end else begin
        over <= 1'b1;
      end
      last_outs <= rd_outs;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      query_minterm <= mt;
      out_bits      <= last_outs & omask_w[pcmc_pkg::OUT_W-1:0];
      cover_count   <= n;
      cover_a       <= covers[0];
      cover_b       <= covers[1];
      cover_c       <= covers[2];
      cover_d       <= covers[3];
      too_many      <= over;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cube_count <= CW'(MAX_CUBES))
    else $error("cube count above capacity");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    rd_vld && over |-> n == pcmc_pkg::CNT_W'(pcmc_pkg::SLOTS))
    else $error("overflow flagged before all slots filled");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> CW'(rd_idx) < cube_count)
    else $error("scan read beyond stored cubes");

endmodule

// ===== design/pla_cube_minterm_cover_top.sv =====
// query: states scan, tail, fin; an empty list goes straight to fin
// the scan reads one stored cube per cycle through the single ram port
// clear and load are done in the idle state; one item is in work at a time
// the result register frees the input side while a result waits
// reset: var_count = 10, out_count = 4, list empty; the cube ram is not cleared
`timescale 1ns / 1ps

module pla_cube_minterm_cover_top #(
  parameter int MAX_CUBES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [pcmc_pkg::VAR_W-1:0]        cube_care,
  input  logic [pcmc_pkg::VAR_W-1:0]        cube_value,
  input  logic [pcmc_pkg::OUT_W-1:0]        cube_outs,
  input  logic [pcmc_pkg::VAR_W-1:0]        minterm,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcmc_pkg::VAR_W-1:0]        query_minterm,
  output logic [pcmc_pkg::OUT_W-1:0]        out_bits,
  output logic [pcmc_pkg::CNT_W-1:0]        cover_count,
  output logic signed [pcmc_pkg::IDX_W-1:0] cover_a,
  output logic signed [pcmc_pkg::IDX_W-1:0] cover_b,
  output logic signed [pcmc_pkg::IDX_W-1:0] cover_c,
  output logic signed [pcmc_pkg::IDX_W-1:0] cover_d,
  output logic                              too_many
);

  localparam logic REG_VAR_COUNT = 1'b0;
  localparam logic REG_OUT_COUNT = 1'b1;

  logic [pcmc_pkg::CFG_W-1:0] var_count;
  logic [pcmc_pkg::CFG_W-1:0] out_count;
  logic                       cfg_wr;
  pcmc_pkg::cmd_t             cmd;
  pcmc_pkg::status_t          status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      var_count <= pcmc_pkg::CFG_W'(10);
      out_count <= pcmc_pkg::CFG_W'(4);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_VAR_COUNT: var_count <= pwdata[pcmc_pkg::CFG_W-1:0];
        REG_OUT_COUNT: out_count <= pwdata[pcmc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VAR_COUNT: prdata = 32'(var_count);
      REG_OUT_COUNT: prdata = 32'(out_count);
      default:       prdata = '0;
    endcase
  end

  pcmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcmc_dp #(
    .MAX_CUBES(MAX_CUBES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .var_count    (var_count),
    .out_count    (out_count),
    .cube_care    (cube_care),
    .cube_value   (cube_value),
    .cube_outs    (cube_outs),
    .minterm      (minterm),
    .query_minterm(query_minterm),
    .out_bits     (out_bits),
    .cover_count  (cover_count),
    .cover_a      (cover_a),
    .cover_b      (cover_b),
    .cover_c      (cover_c),
    .cover_d      (cover_d),
    .too_many     (too_many)
  );

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && cover_count == '0 |-> out_bits == '0 && cover_a == '1 && !too_many)
    else $error("uncovered result carries cover data");

endmodule

// ===== sim/pla_cube_minterm_cover_top_tb.sv =====
// self-checking testbench for the pla cube cover lookup: directed and random cube lists,
// queries under several var_count/out_count settings, random gaps and result stalls
// depends on design/pcmc_pkg.sv and design/pla_cube_minterm_cover_top.sv
`timescale 1ns / 1ps

module pla_cube_minterm_cover_top_tb;

  localparam int MAX_CUBES = 256;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] REG_VAR_COUNT = 3'd0;
  localparam logic [2:0] REG_OUT_COUNT = 3'd4;

  typedef struct packed {
    logic [pcmc_pkg::VAR_W-1:0] mt;
    logic [pcmc_pkg::OUT_W-1:0] outs;
    logic [pcmc_pkg::CNT_W-1:0] count;
    logic [pcmc_pkg::IDX_W-1:0] idx_a;
    logic [pcmc_pkg::IDX_W-1:0] idx_b;
    logic [pcmc_pkg::IDX_W-1:0] idx_c;
    logic [pcmc_pkg::IDX_W-1:0] idx_d;
    logic                       many;
  } cover_res_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 action = pcmc_pkg::ACT_CLEAR;
  logic [pcmc_pkg::VAR_W-1:0] cube_care = '0;
  logic [pcmc_pkg::VAR_W-1:0] cube_value = '0;
  logic [pcmc_pkg::OUT_W-1:0] cube_outs = '0;
  logic [pcmc_pkg::VAR_W-1:0] minterm = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [pcmc_pkg::VAR_W-1:0] query_minterm;
  logic [pcmc_pkg::OUT_W-1:0] out_bits;
  logic [pcmc_pkg::CNT_W-1:0] cover_count;
  logic signed [pcmc_pkg::IDX_W-1:0] cover_a, cover_b, cover_c, cover_d;
  logic                       too_many;

  // shadow copy of the cube list and registers
  logic [pcmc_pkg::VAR_W-1:0] care_tbl  [MAX_CUBES];
  logic [pcmc_pkg::VAR_W-1:0] value_tbl [MAX_CUBES];
  logic [pcmc_pkg::OUT_W-1:0] outs_tbl  [MAX_CUBES];
  int                         cube_total = 0;
  logic [pcmc_pkg::CFG_W-1:0] var_sel = 4'd10;
  logic [pcmc_pkg::CFG_W-1:0] out_sel = 4'd4;

  cover_res_t pending_covers[$];
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  int calm_left = 0;

  pla_cube_minterm_cover_top #(.MAX_CUBES(MAX_CUBES)) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .cube_care(cube_care),
    .cube_value(cube_value), .cube_outs(cube_outs), .minterm(minterm),
    .out_valid(out_valid), .out_stall(out_stall), .query_minterm(query_minterm),
    .out_bits(out_bits), .cover_count(cover_count), .cover_a(cover_a), .cover_b(cover_b),
    .cover_c(cover_c), .cover_d(cover_d), .too_many(too_many)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure: short and long stalls, calm stretches
  always @(posedge clk) begin : stall_gen
    int pick;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        calm_left = $urandom_range(0, 6);
        out_stall <= 1'b0;
      end else if (pick < 85) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else if (pick < 95) begin
        calm_left = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end else begin
        stall_left = $urandom_range(10, 50);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic cover_res_t predict_cover(logic [pcmc_pkg::VAR_W-1:0] mt);
    cover_res_t res;
    int vars_used, outs_used, hits, k;
    logic [pcmc_pkg::VAR_W-1:0] vmask;
    logic [pcmc_pkg::OUT_W-1:0] omask, last_outs;
    logic [pcmc_pkg::IDX_W-1:0] idx [pcmc_pkg::SLOTS];
    logic many;
    vars_used = (var_sel > pcmc_pkg::MAX_VARS) ? pcmc_pkg::MAX_VARS : var_sel;
    outs_used = (out_sel > pcmc_pkg::MAX_OUTS) ? pcmc_pkg::MAX_OUTS : out_sel;
    vmask = pcmc_pkg::VAR_W'((1 << vars_used) - 1);
    omask = pcmc_pkg::OUT_W'((1 << outs_used) - 1);
    hits = 0;
    many = 1'b0;
    last_outs = '0;
    foreach (idx[i]) idx[i] = '1;
    for (k = 0; k < cube_total; k++) begin
      if (((mt ^ value_tbl[k]) & care_tbl[k] & vmask) == '0) begin
        if (hits < pcmc_pkg::SLOTS) begin
          idx[hits] = pcmc_pkg::IDX_W'(k);
          hits++;
        end else begin
          many = 1'b1;
        end
        last_outs = outs_tbl[k];
      end
    end
    res.mt = mt;
    res.outs = last_outs & omask;
    res.count = pcmc_pkg::CNT_W'(hits);
    res.idx_a = idx[0];
    res.idx_b = idx[1];
    res.idx_c = idx[2];
    res.idx_d = idx[3];
    res.many = many;
    return res;
  endfunction

  function automatic void update_cover_model(logic [1:0] act,
                                             logic [pcmc_pkg::VAR_W-1:0] care,
                                             logic [pcmc_pkg::VAR_W-1:0] val,
                                             logic [pcmc_pkg::OUT_W-1:0] outs,
                                             logic [pcmc_pkg::VAR_W-1:0] mt);
    case (act)
      pcmc_pkg::ACT_CLEAR: cube_total = 0;
      pcmc_pkg::ACT_LOAD: begin
        // a full list drops the load
        if (cube_total < MAX_CUBES) begin
          care_tbl[cube_total] = care;
          value_tbl[cube_total] = val;
          outs_tbl[cube_total] = outs;
          cube_total++;
        end
      end
      pcmc_pkg::ACT_QUERY: pending_covers.push_back(predict_cover(mt));
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    cover_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_covers.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none actual minterm %0d",
                 $time, query_minterm);
      end else begin
        want = pending_covers.pop_front();
        check_field("query_minterm", want.mt, query_minterm);
        check_field("out_bits", want.outs, out_bits);
        check_field("cover_count", want.count, cover_count);
        check_field("cover_a", $signed(want.idx_a), cover_a);
        check_field("cover_b", $signed(want.idx_b), cover_b);
        check_field("cover_c", $signed(want.idx_c), cover_c);
        check_field("cover_d", $signed(want.idx_d), cover_d);
        check_field("too_many", want.many, too_many);
      end
    end
  end

  function automatic int next_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high after a transfer with no gap; the next call or a drain takes it over
  task automatic send_item(logic [1:0] act, logic [pcmc_pkg::VAR_W-1:0] care,
                           logic [pcmc_pkg::VAR_W-1:0] val,
                           logic [pcmc_pkg::OUT_W-1:0] outs,
                           logic [pcmc_pkg::VAR_W-1:0] mt);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    cube_care <= care;
    cube_value <= val;
    cube_outs <= outs;
    minterm <= mt;
    do @(posedge clk); while (in_stall);
    update_cover_model(act, care, val, outs, mt);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [pcmc_pkg::VAR_W-1:0] rand_var();
    return pcmc_pkg::VAR_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [pcmc_pkg::OUT_W-1:0] rand_outs();
    return pcmc_pkg::OUT_W'($urandom_range(0, 8191));
  endfunction

  function automatic logic [pcmc_pkg::VAR_W-1:0] pick_care();
    case ($urandom_range(0, 3))
      0: return pcmc_pkg::VAR_W'($urandom & $urandom & $urandom);
      1: return rand_var();
      2: return rand_var() | rand_var();
      default: return pcmc_pkg::VAR_W'($urandom & $urandom & $urandom & $urandom);
    endcase
  endfunction

  // mostly a minterm inside some stored cube, don't-care bits random
  function automatic logic [pcmc_pkg::VAR_W-1:0] pick_minterm();
    int k;
    if (cube_total > 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, cube_total - 1);
      return (value_tbl[k] & care_tbl[k]) | (rand_var() & ~care_tbl[k]);
    end
    return rand_var();
  endfunction

  task automatic send_clear();
    send_item(pcmc_pkg::ACT_CLEAR, rand_var(), rand_var(), rand_outs(), rand_var());
  endtask

  task automatic send_load(logic [pcmc_pkg::VAR_W-1:0] care,
                           logic [pcmc_pkg::VAR_W-1:0] val,
                           logic [pcmc_pkg::OUT_W-1:0] outs);
    send_item(pcmc_pkg::ACT_LOAD, care, val, outs, rand_var());
  endtask

  task automatic send_query(logic [pcmc_pkg::VAR_W-1:0] mt);
    send_item(pcmc_pkg::ACT_QUERY, rand_var(), rand_var(), rand_outs(), mt);
  endtask

  // block idle: all results in, then room for a scan of a full list
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_covers.size() != 0) @(posedge clk);
    repeat (MAX_CUBES + 8) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [pcmc_pkg::CFG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= ($urandom & 32'hFFFF_FFF0) | val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == REG_VAR_COUNT) var_sel = val;
    else out_sel = val;
  endtask

  task automatic check_reg(string name, logic [2:0] addr,
                           logic [pcmc_pkg::CFG_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {28'd0, want}) begin
      errors++;
      $display("%0t ns: %s readback mismatch, expected %0d actual %0d",
               $time, name, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [pcmc_pkg::CFG_W-1:0] vars,
                            logic [pcmc_pkg::CFG_W-1:0] outs);
    apb_write(REG_VAR_COUNT, vars);
    apb_write(REG_OUT_COUNT, outs);
    check_reg("var_count", REG_VAR_COUNT, var_sel);
    check_reg("out_count", REG_OUT_COUNT, out_sel);
  endtask

  task automatic test_reset_values();
    check_reg("var_count", REG_VAR_COUNT, 4'd10);
    check_reg("out_count", REG_OUT_COUNT, 4'd4);
  endtask

  task automatic test_directed_covers();
    send_query(10'h3FF);                                  // empty list
    send_item(ACT_UNUSED, rand_var(), rand_var(), rand_outs(), rand_var());
    send_load(10'h000, 10'h3FF, 13'h1FFF);                // covers everything
    send_load(10'h3FF, 10'h3FF, 13'h0001);
    send_load(10'h3FF, 10'h000, 13'h1000);
    send_load(10'h155, 10'h155, 13'h0AAA);
    send_query(10'h3FF);
    send_query(10'h000);
    send_query(10'h155);
    send_load(10'h001, 10'h000, 13'h1555);
    send_load(10'h001, 10'h000, 13'h0555);
    send_query(10'h000);                                  // exactly four covers
    send_query(10'h2AA);
    send_load(10'h000, 10'h000, 13'h0F0F);
    send_query(10'h000);                                  // fifth cover sets too_many
    send_query(10'h001);
    send_clear();
    send_query(10'h000);
    send_load(10'h200, 10'h200, 13'h1FFF);
    send_query(10'h200);
    send_query(10'h1FF);
    send_item(ACT_UNUSED, 10'h3FF, 10'h3FF, 13'h1FFF, 10'h3FF);
    send_query(10'h3FF);
  endtask

  task automatic test_full_list();
    int k;
    drain();
    send_clear();
    for (k = 0; k < MAX_CUBES; k++)
      send_load(pcmc_pkg::VAR_W'($urandom & $urandom), rand_var(), rand_outs());
    send_load(10'h000, 10'h000, 13'h1FFF);                // dropped, list is full
    for (k = 0; k < 12; k++) send_query(pick_minterm());
    drain();
    set_config(4'd0, 4'd13);                              // no variable compared
    for (k = 0; k < 3; k++) send_query(rand_var());
  endtask

  // well-formed clear/load/query sequences with some noise mixed in
  task automatic run_traffic(int n_items);
    int sent, nload, nq, k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) < 7 || cube_total > 200) begin
          send_clear();
          sent++;
        end
        nload = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (k = 0; k < nload; k++) send_load(pick_care(), rand_var(), rand_outs());
        nq = $urandom_range(2, 10);
        for (k = 0; k < nq; k++) send_query(pick_minterm());
        sent += nload + nq;
      end else begin
        case ($urandom_range(0, 2))
          0: send_item(ACT_UNUSED, rand_var(), rand_var(), rand_outs(), rand_var());
          1: begin
            send_query(rand_var());
            sent++;
          end
          default: begin
            send_load(pick_care(), rand_var(), rand_outs());
            sent++;
          end
        endcase
      end
    end
  endtask

  task automatic test_config_sweep();
    logic [pcmc_pkg::CFG_W-1:0] var_list [8];
    logic [pcmc_pkg::CFG_W-1:0] out_list [8];
    int p;
    var_list = '{4'd0, 4'd15, 4'd1, 4'd10, 4'd11, 4'd5, 4'd0, 4'd0};
    out_list = '{4'd0, 4'd15, 4'd13, 4'd1, 4'd14, 4'd7, 4'd0, 4'd0};
    var_list[6] = pcmc_pkg::CFG_W'($urandom_range(0, 15));
    out_list[6] = pcmc_pkg::CFG_W'($urandom_range(0, 15));
    var_list[7] = pcmc_pkg::CFG_W'($urandom_range(0, 15));
    out_list[7] = pcmc_pkg::CFG_W'($urandom_range(0, 15));
    for (p = 0; p < 8; p++) begin
      drain();
      set_config(var_list[p], out_list[p]);
      run_traffic(170);
    end
  endtask

  task automatic test_default_traffic();
    drain();
    set_config(4'd10, 4'd4);
    run_traffic(300);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed_covers();
    test_full_list();
    test_config_sweep();
    test_default_traffic();
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pcmc_pkg.sv
design/pcmc_ram.sv
design/pcmc_ctrl.sv
design/pcmc_dp.sv
design/pla_cube_minterm_cover_top.sv
sim/pla_cube_minterm_cover_top_tb.sv
